// ----- rtl/gac_pkg.sv -----
// Shared types and constants for the GHASH accumulator.
// Used by the front end, the item queue, the back end and the top level.
`default_nettype none

package gac_pkg;

    localparam int HALF_W      = 64;
    localparam int BLOCK_W     = 2 * HALF_W;
    localparam int BLOCK_BYTES = BLOCK_W / 8;
    localparam int COUNT_W     = 5;

    // Configuration register indexes.
    localparam logic REG_HASH_KEY_HIGH = 1'b0;
    localparam logic REG_HASH_KEY_LOW  = 1'b1;

    // Queue between the front end and the back end.
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // One classified block on its way to the accumulator.
    typedef struct packed {
        logic [BLOCK_W-1:0] data;     // masked block, byte 0 in the top bits
        logic               restart;  // clear the accumulator first
        logic               has_data; // at least one valid byte: multiply
    } gac_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } gac_fifo_stat_t;

endpackage

`default_nettype wire

// ----- rtl/ghash_accumulator_core.sv -----
// GHASH accumulator: XORs each 128-bit block into the accumulator and multiplies by H
// (no multiply for a block with no valid bytes); blocks pass through the queue into the
// accumulator register. Throughput: one block per cycle while the output is not held; the
// GF(2^128) multiply is in the feedback loop; the two-entry queue absorbs output stalls.
// Reset (synchronous, aresetn low) clears the hash key, the accumulator and the queue.
// Depends on gac_pkg, gac_front, gac_fifo, gac_gfmul and gac_back.
`default_nettype none

module ghash_accumulator_core import gac_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  logic [HALF_W-1:0]   cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [HALF_W-1:0]   s_data_high,
    input  logic [HALF_W-1:0]   s_data_low,
    input  logic [COUNT_W-1:0]  s_valid_bytes,
    input  logic                s_restart,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [HALF_W-1:0]   m_digest_high,
    output logic [HALF_W-1:0]   m_digest_low
);

    logic [HALF_W-1:0]  key_high_reg, key_high_next;
    logic [HALF_W-1:0]  key_low_reg,  key_low_next;
    logic               push;
    logic               pop;
    gac_item_t          push_item;
    gac_item_t          pop_item;
    gac_fifo_stat_t     fifo_stat;
    logic [BLOCK_W-1:0] digest;

    always_comb begin
        key_high_next = key_high_reg;
        key_low_next  = key_low_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_HASH_KEY_HIGH: key_high_next = cfg_wdata;
                REG_HASH_KEY_LOW:  key_low_next  = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end else begin
            key_high_reg <= key_high_next;
            key_low_reg  <= key_low_next;
        end
    end

    gac_front u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_high   (s_data_high),
        .s_data_low    (s_data_low),
        .s_valid_bytes (s_valid_bytes),
        .s_restart     (s_restart),
        .fifo_stat     (fifo_stat),
        .push          (push),
        .item          (push_item)
    );

    gac_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .stat      (fifo_stat)
    );

    gac_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item      (pop_item),
        .fifo_stat (fifo_stat),
        .pop       (pop),
        .hash_key  ({key_high_reg, key_low_reg}),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .digest    (digest)
    );

    assign m_digest_high = digest[BLOCK_W-1:HALF_W];
    assign m_digest_low  = digest[HALF_W-1:0];

    // A zero key must leave a zero accumulator after any multiply.
    a_zero_key: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && pop_item.has_data && key_high_reg == '0 && key_low_reg == '0
        |=> m_valid && digest == '0)
        else $error("multiply by a zero key left a nonzero accumulator");

    // A restart with no valid bytes returns an all-zero digest.
    a_restart_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && pop_item.restart && !pop_item.has_data |=> m_valid && digest == '0)
        else $error("restart without data did not clear the accumulator");

    // A result only appears after an item was taken from the queue.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(pop))
        else $error("result shown without a queued transaction");

    // While the queue holds an item and the result slot frees up, the back end takes it.
    a_no_idle_back: assert property (@(posedge aclk) disable iff (!aresetn)
        !fifo_stat.empty && (!m_valid || m_ready) |-> pop)
        else $error("back end idled with work queued");

endmodule

`default_nettype wire

// ----- rtl/gac_front.sv -----
// Front end: accepts input transactions, masks unused bytes and classifies them.
// Depends on gac_pkg; writes into the item queue.
`default_nettype none

module gac_front import gac_pkg::*; (
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [HALF_W-1:0]   s_data_high,
    input  logic [HALF_W-1:0]   s_data_low,
    input  logic [COUNT_W-1:0]  s_valid_bytes,
    input  logic                s_restart,
    input  gac_fifo_stat_t      fifo_stat,
    output logic                push,
    output gac_item_t           item
);

    logic [COUNT_W-1:0] count_sat;
    logic [BLOCK_W-1:0] byte_mask;

    // Counts above a full block are treated as a full block.
    assign count_sat = (s_valid_bytes > COUNT_W'(BLOCK_BYTES)) ? COUNT_W'(BLOCK_BYTES)
                                                             : s_valid_bytes;

    always_comb begin
        byte_mask = '0;
        for (int j = 0; j < BLOCK_BYTES; j++) begin
            byte_mask[BLOCK_W-1-8*j -: 8] = (COUNT_W'(j) < count_sat) ? 8'hff : 8'h00;
        end
    end

    assign s_ready       = !fifo_stat.full;
    assign push          = s_valid && s_ready;
    assign item.data     = {s_data_high, s_data_low} & byte_mask;
    assign item.restart  = s_restart;
    assign item.has_data = (count_sat != '0);

endmodule

`default_nettype wire

// ----- rtl/gac_fifo.sv -----
// Short queue of classified items between the front end and the back end.
// Depends on gac_pkg for the item type and the queue depth.
`default_nettype none

module gac_fifo import gac_pkg::*; (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  gac_item_t      push_item,
    input  logic           pop,
    output gac_item_t      pop_item,
    output gac_fifo_stat_t stat
);

    gac_item_t            mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0]   count_reg,  count_next;

    function automatic logic [FIFO_AW-1:0] ptr_inc(input logic [FIFO_AW-1:0] ptr);
        ptr_inc = (ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_item   = mem[rd_ptr_reg];
    assign stat.full  = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

`default_nettype wire

// ----- rtl/gac_gfmul.sv -----
// GF(2^128) multiplier in GCM bit order, reduction polynomial x^128+x^7+x^2+x+1.
// Depends on gac_pkg for the block width.
`default_nettype none

module gac_gfmul import gac_pkg::*; (
    input  logic [BLOCK_W-1:0] x,
    input  logic [BLOCK_W-1:0] h,
    output logic [BLOCK_W-1:0] z
);

    always_comb begin
        logic [BLOCK_W-1:0]   a;
        logic [BLOCK_W-1:0]   b;
        logic [2*BLOCK_W-2:0] prod;
        logic [BLOCK_W-2:0]   hi;
        logic [BLOCK_W+5:0]   fold1;
        logic [5:0]           over;
        logic [BLOCK_W-1:0]   fold2;
        logic [BLOCK_W-1:0]   r;

        // GCM bit 0 is the most significant bit of byte 0; reverse so that
        // bit i holds the coefficient of x^i.
        for (int i = 0; i < BLOCK_W; i++) begin
            a[i] = x[BLOCK_W-1-i];
            b[i] = h[BLOCK_W-1-i];
        end

        // Carry-less product: an XOR of independent partial products.
        prod = '0;
        for (int i = 0; i < BLOCK_W; i++) begin
            prod = prod ^ (({{(BLOCK_W-1){1'b0}}, b} & {(2*BLOCK_W-1){a[i]}}) << i);
        end

        // Fold the upper half down twice using x^128 = x^7 + x^2 + x + 1.
        hi    = prod[2*BLOCK_W-2:BLOCK_W];
        fold1 = {7'b0, hi} ^ {6'b0, hi, 1'b0} ^ {5'b0, hi, 2'b0} ^ {hi, 7'b0};
        over  = fold1[BLOCK_W+5:BLOCK_W];
        fold2 = {{(BLOCK_W-6){1'b0}}, over}
              ^ {{(BLOCK_W-7){1'b0}}, over, 1'b0}
              ^ {{(BLOCK_W-8){1'b0}}, over, 2'b0}
              ^ {{(BLOCK_W-13){1'b0}}, over, 7'b0};
        r = prod[BLOCK_W-1:0] ^ fold1[BLOCK_W-1:0] ^ fold2;

        for (int i = 0; i < BLOCK_W; i++) begin
            z[BLOCK_W-1-i] = r[i];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/gac_back.sv -----
// Back end: takes items from the queue, updates the accumulator and holds the result.
// Depends on gac_pkg and instantiates gac_gfmul.
`default_nettype none

module gac_back import gac_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  gac_item_t          item,
    input  gac_fifo_stat_t     fifo_stat,
    output logic               pop,
    input  logic [BLOCK_W-1:0] hash_key,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [BLOCK_W-1:0] digest
);

    logic [BLOCK_W-1:0] acc_reg, acc_next;
    logic               valid_reg, valid_next;
    logic [BLOCK_W-1:0] acc_base;
    logic [BLOCK_W-1:0] product;

    // The accumulator doubles as the result register: it changes only when
    // a new result is loaded, so a stalled result stays put.
    assign pop      = !fifo_stat.empty && (!valid_reg || m_ready);
    assign acc_base = item.restart ? '0 : acc_reg;

    gac_gfmul u_gfmul (
        .x (acc_base ^ item.data),
        .h (hash_key),
        .z (product)
    );

    always_comb begin
        acc_next   = acc_reg;
        valid_next = valid_reg && !m_ready;
        if (pop) begin
            acc_next   = item.has_data ? product : acc_base;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            acc_reg   <= acc_next;
            valid_reg <= valid_next;
        end
    end

    assign m_valid = valid_reg;
    assign digest  = acc_reg;

endmodule

`default_nettype wire
